// ===== rtl/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int unsigned CAP_W     = 6;
    localparam int unsigned CAP_RESET = 32;
    localparam int unsigned FAULT_W   = 16;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    typedef struct packed {
        logic [7:0] page_number;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [4:0]  frame_index;
        logic        evicted_valid;
        logic [7:0]  evicted_page;
        logic [15:0] fault_total;
    } t_res;

    typedef struct packed {
        logic [CAP_W-1:0] frame_capacity;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FILL,
        ST_SWEEP,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        OP_IDLE,
        OP_SEARCH,
        OP_FILL,
        OP_SWEEP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     flush;
        logic     inject;
    } t_cell_ctl;

    typedef struct packed {
        logic tok;
        logic hit;
        logic evict;
        logic pass_next;
        logic pass_wrap;
    } t_cell_stat;

endpackage

// ===== rtl/cpr_stream_if.sv =====
// ----------------------------------------------------------------------------
// cpr_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface cpr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cpr_cell.sv =====
// ----------------------------------------------------------------------------
// cpr_cell
// One page frame: tag, reference bit and the travelling search/sweep token.
// ----------------------------------------------------------------------------
module cpr_cell #(
    parameter int unsigned IDX       = 0,
    parameter int unsigned PAGE_BITS = 8,
    parameter int unsigned POS_W     = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cpr_pkg::t_cell_ctl     i_ctl,
    input  logic [PAGE_BITS-1:0]   i_page,
    input  logic [POS_W-1:0]       i_cap_last,
    input  logic [POS_W-1:0]       i_inject_pos,
    input  logic                   i_tok,
    output cpr_pkg::t_cell_stat    o_stat,
    output logic [PAGE_BITS-1:0]   o_tag
);
    import cpr_pkg::*;

    logic                 r_tok;
    logic                 n_tok;
    logic                 r_ref;
    logic                 n_ref;
    logic [PAGE_BITS-1:0] r_tag;
    logic [PAGE_BITS-1:0] n_tag;
    logic                 pass;
    logic                 hit;
    logic                 evict;
    logic                 is_last;

    assign is_last = (i_cap_last == POS_W'(IDX));

    always_comb begin
        n_ref = r_ref;
        n_tag = r_tag;
        pass  = 1'b0;
        hit   = 1'b0;
        evict = 1'b0;
        unique case (i_ctl.op)
            OP_SEARCH: begin
                if (r_tok) begin
                    if (r_tag == i_page) begin
                        hit   = 1'b1;
                        n_ref = 1'b1;
                    end else begin
                        pass = 1'b1;
                    end
                end
            end
            OP_FILL: begin
                if (r_tok) begin
                    n_tag = i_page;
                    n_ref = 1'b1;
                end
            end
            OP_SWEEP: begin
                if (r_tok) begin
                    if (r_ref) begin
                        n_ref = 1'b0;
                        pass  = 1'b1;
                    end else begin
                        evict = 1'b1;
                        n_tag = i_page;
                        n_ref = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        n_tok = (i_ctl.inject && (i_inject_pos == POS_W'(IDX))) || (i_tok && !i_ctl.flush);
    end

    assign o_stat.tok       = r_tok;
    assign o_stat.hit       = hit;
    assign o_stat.evict     = evict;
    assign o_stat.pass_next = pass && !is_last;
    assign o_stat.pass_wrap = pass && is_last;
    assign o_tag            = evict ? r_tag : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
            r_ref <= 1'b0;
        end else begin
            r_tok <= n_tok;
            r_ref <= n_ref;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

endmodule

// ===== rtl/clock_page_replacement.sv =====
// ----------------------------------------------------------------------------
// clock_page_replacement
// Second-chance page replacement over a row of frame cells.
//
//   Channel     Dir  Payload                                      Handshake
//   i_page_ch   in   page_number                                  valid/ready
//   i_cfg_ch    in   frame_capacity                               valid/ready
//   o_res_ch    out  hit, frame_index, evicted_valid,             valid/ready
//                    evicted_page, fault_total
//
// A reference takes a start step, a search step per frame searched, a fill
// step or, when a full set must evict, a sweep step per frame swept, and a
// result step; the search and sweep follow the token walking the cell row.
// Reset clears all reference bits, the fill count, the hand and the fault
// count at once; the capacity returns to 32.
// A result waits in the output register while the next reference is taken.
// ----------------------------------------------------------------------------
module clock_page_replacement #(
    parameter int unsigned MAX_FRAMES = 32,
    parameter int unsigned PAGE_BITS  = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpr_stream_if.sink    i_page_ch,
    cpr_stream_if.sink    i_cfg_ch,
    cpr_stream_if.source  o_res_ch
);
    import cpr_pkg::*;

    localparam int unsigned FILL_W = $clog2(MAX_FRAMES + 1);
    localparam int unsigned POS_W  = $clog2(MAX_FRAMES);

    t_state               r_state;
    t_state               n_state;
    logic [CAP_W-1:0]     r_cfg_cap;
    logic [FILL_W-1:0]    r_filled;
    logic [FILL_W-1:0]    n_filled;
    logic [POS_W-1:0]     r_hand;
    logic [POS_W-1:0]     n_hand;
    logic [FAULT_W-1:0]   r_fault;
    logic [FAULT_W-1:0]   n_fault;
    logic [PAGE_BITS-1:0] r_page;
    logic [PAGE_BITS-1:0] n_page;
    logic [FILL_W-1:0]    r_cap;
    logic [FILL_W-1:0]    n_cap;
    logic [POS_W-1:0]     r_cap_last;
    logic [POS_W-1:0]     n_cap_last;
    logic [FILL_W-1:0]    r_used;
    logic [FILL_W-1:0]    n_used;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;
    logic                 r_res_hit;
    logic                 n_res_hit;
    logic [POS_W-1:0]     r_res_idx;
    logic [POS_W-1:0]     n_res_idx;
    logic                 r_res_ev;
    logic                 n_res_ev;
    logic [PAGE_BITS-1:0] r_res_evpage;
    logic [PAGE_BITS-1:0] n_res_evpage;
    t_res                 r_out;
    logic                 r_out_valid;
    logic                 out_load;

    logic [31:0]          cfg_wide;
    logic [FILL_W-1:0]    cap_c;
    logic [FILL_W-1:0]    used_c;
    logic [POS_W-1:0]     hand_start;
    logic [POS_W-1:0]     pos_wrap;

    t_cell_ctl            cell_ctl;
    logic [POS_W-1:0]     inject_pos;
    t_cell_stat           stat [MAX_FRAMES];
    logic [PAGE_BITS-1:0] tag_vec [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] tok_vec;
    logic [MAX_FRAMES-1:0] hit_vec;
    logic [MAX_FRAMES-1:0] evict_vec;
    logic [MAX_FRAMES-1:0] wrap_vec;
    logic                 wrap_tok;
    logic                 any_hit;
    logic                 any_evict;
    logic [PAGE_BITS-1:0] ev_tag;

    // Cell row. The token moves one cell per cycle and wraps at the last
    // active frame back to frame 0.
    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        logic tok_in;
        if (g == 0) begin : g_first
            assign tok_in = wrap_tok;
        end else begin : g_rest
            assign tok_in = stat[g-1].pass_next;
        end

        cpr_cell #(
            .IDX       (g),
            .PAGE_BITS (PAGE_BITS),
            .POS_W     (POS_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_page       (r_page),
            .i_cap_last   (r_cap_last),
            .i_inject_pos (inject_pos),
            .i_tok        (tok_in),
            .o_stat       (stat[g]),
            .o_tag        (tag_vec[g])
        );

        assign tok_vec[g]   = stat[g].tok;
        assign hit_vec[g]   = stat[g].hit;
        assign evict_vec[g] = stat[g].evict;
        assign wrap_vec[g]  = stat[g].pass_wrap;
    end

    assign wrap_tok  = |wrap_vec;
    assign any_hit   = |hit_vec;
    assign any_evict = |evict_vec;

    always_comb begin
        ev_tag = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            ev_tag = ev_tag | tag_vec[i];
        end
    end

    always_comb begin
        cfg_wide = 32'(r_cfg_cap);
        if (cfg_wide == 32'd0) begin
            cap_c = FILL_W'(1);
        end else if (cfg_wide > 32'(MAX_FRAMES)) begin
            cap_c = FILL_W'(MAX_FRAMES);
        end else begin
            cap_c = FILL_W'(cfg_wide);
        end
        used_c     = (r_filled < cap_c) ? r_filled : cap_c;
        hand_start = (FILL_W'(r_hand) >= r_cap) ? '0 : r_hand;
        pos_wrap   = (r_pos == r_cap_last) ? '0 : r_pos + POS_W'(1);
    end

    always_comb begin
        n_state      = r_state;
        n_filled     = r_filled;
        n_hand       = r_hand;
        n_fault      = r_fault;
        n_page       = r_page;
        n_cap        = r_cap;
        n_cap_last   = r_cap_last;
        n_used       = r_used;
        n_pos        = r_pos;
        n_res_hit    = r_res_hit;
        n_res_idx    = r_res_idx;
        n_res_ev     = r_res_ev;
        n_res_evpage = r_res_evpage;
        cell_ctl     = '{op: OP_IDLE, flush: 1'b0, inject: 1'b0};
        inject_pos   = '0;
        out_load     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_page_ch.valid) begin
                    n_page          = PAGE_BITS'(i_page_ch.data.page_number);
                    n_cap           = cap_c;
                    n_cap_last      = POS_W'(cap_c - FILL_W'(1));
                    n_used          = used_c;
                    n_pos           = '0;
                    cell_ctl.inject = 1'b1;
                    n_state         = (used_c == '0) ? ST_FILL : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cell_ctl.op = OP_SEARCH;
                if (any_hit) begin
                    n_res_hit    = 1'b1;
                    n_res_idx    = r_pos;
                    n_res_ev     = 1'b0;
                    n_res_evpage = '0;
                    n_state      = ST_RESULT;
                end else if (FILL_W'(r_pos) + FILL_W'(1) == r_used) begin
                    if (r_used < r_cap) begin
                        n_pos   = r_pos + POS_W'(1);
                        n_state = ST_FILL;
                    end else begin
                        cell_ctl.flush  = 1'b1;
                        cell_ctl.inject = 1'b1;
                        inject_pos      = hand_start;
                        n_pos           = hand_start;
                        n_state         = ST_SWEEP;
                    end
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
            ST_FILL: begin
                cell_ctl.op  = OP_FILL;
                n_filled     = r_used + FILL_W'(1);
                n_fault      = (r_fault == FAULT_MAX) ? r_fault : r_fault + FAULT_W'(1);
                n_res_hit    = 1'b0;
                n_res_idx    = r_pos;
                n_res_ev     = 1'b0;
                n_res_evpage = '0;
                n_state      = ST_RESULT;
            end
            ST_SWEEP: begin
                cell_ctl.op = OP_SWEEP;
                if (any_evict) begin
                    n_fault      = (r_fault == FAULT_MAX) ? r_fault : r_fault + FAULT_W'(1);
                    n_hand       = pos_wrap;
                    n_res_hit    = 1'b0;
                    n_res_idx    = r_pos;
                    n_res_ev     = 1'b1;
                    n_res_evpage = ev_tag;
                    n_state      = ST_RESULT;
                end else begin
                    n_pos = pos_wrap;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || o_res_ch.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_page_ch.ready = (r_state == ST_IDLE);
    assign i_cfg_ch.ready  = 1'b1;
    assign o_res_ch.valid  = r_out_valid;
    assign o_res_ch.data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_cap   <= CAP_W'(CAP_RESET);
            r_filled    <= '0;
            r_hand      <= '0;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_filled <= n_filled;
            r_hand   <= n_hand;
            r_fault  <= n_fault;
            if (i_cfg_ch.valid) begin
                r_cfg_cap <= i_cfg_ch.data.frame_capacity;
            end
            r_out_valid <= out_load || (r_out_valid && !o_res_ch.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_page       <= n_page;
        r_cap        <= n_cap;
        r_cap_last   <= n_cap_last;
        r_used       <= n_used;
        r_pos        <= n_pos;
        r_res_hit    <= n_res_hit;
        r_res_idx    <= n_res_idx;
        r_res_ev     <= n_res_ev;
        r_res_evpage <= n_res_evpage;
        if (out_load) begin
            r_out.hit           <= r_res_hit;
            r_out.frame_index   <= 5'(r_res_idx);
            r_out.evicted_valid <= r_res_ev;
            r_out.evicted_page  <= 8'(r_res_evpage);
            r_out.fault_total   <= r_fault;
        end
    end

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH || r_state == ST_FILL || r_state == ST_SWEEP)
            |-> $onehot(tok_vec))
        else $error("token count in cell row is not one while a reference is active");

    a_no_token_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_RESULT) |-> (tok_vec == '0))
        else $error("stray token in cell row between references");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({hit_vec, evict_vec}))
        else $error("more than one cell reported a hit or an eviction");

    a_evict_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        any_evict |-> (r_state == ST_SWEEP))
        else $error("eviction reported outside a sweep");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= FILL_W'(MAX_FRAMES))
        else $error("fill count exceeds the number of frames");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clock page replacement block. A scoreboard
// class keeps its own copy of the frame table, reference bits, fill count,
// hand and fault count, predicts the result of every accepted reference and
// compares each result field by field. Stimulus runs a directed walk through
// the capacity corner cases, random phases with page locality under several
// capacities and idling patterns, a long receiver hold-off, and a final run
// in which every reference after the first misses.
// ----------------------------------------------------------------------------
module tb_top;
    import cpr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned PHASE_ITEMS = 130;
    localparam int unsigned MISS_REFS   = 80;

    class replacement_scoreboard;
        t_res        expected_results[$];
        logic [7:0]  frame_tag [32];
        logic        ref_bit [32];
        int unsigned filled_count;
        int unsigned hand_pos;
        logic [15:0] fault_count;
        logic [5:0]  capacity_reg;
        int unsigned errors;

        function new();
            for (int i = 0; i < 32; i++) begin
                frame_tag[i] = '0;
                ref_bit[i] = 1'b0;
            end
            filled_count = 0;
            hand_pos = 0;
            fault_count = '0;
            capacity_reg = CAP_W'(CAP_RESET);
            errors = 0;
        endfunction

        function void set_capacity(logic [5:0] value);
            capacity_reg = value;
        endfunction

        function int unsigned live_frames();
            if (capacity_reg == 0) begin
                return 1;
            end
            if (capacity_reg > 32) begin
                return 32;
            end
            return capacity_reg;
        endfunction

        function void note_reference(t_req req);
            int unsigned cap;
            int unsigned used;
            int unsigned h;
            t_res r;
            cap = live_frames();
            used = (filled_count < cap) ? filled_count : cap;
            r = '0;
            for (int i = 0; i < used; i++) begin
                if (frame_tag[i] == req.page_number) begin
                    r.hit = 1'b1;
                    r.frame_index = 5'(i);
                    ref_bit[i] = 1'b1;
                    break;
                end
            end
            if (!r.hit) begin
                if (fault_count != FAULT_MAX) begin
                    fault_count++;
                end
                if (used < cap) begin
                    r.frame_index = 5'(used);
                    frame_tag[used] = req.page_number;
                    ref_bit[used] = 1'b1;
                    filled_count = used + 1;
                end else begin
                    h = (hand_pos >= cap) ? 0 : hand_pos;
                    for (int n = 0; n <= cap; n++) begin
                        if (!ref_bit[h]) begin
                            break;
                        end
                        ref_bit[h] = 1'b0;
                        h = (h + 1) % cap;
                    end
                    r.frame_index = 5'(h);
                    r.evicted_valid = 1'b1;
                    r.evicted_page = frame_tag[h];
                    frame_tag[h] = req.page_number;
                    ref_bit[h] = 1'b1;
                    hand_pos = (h + 1) % cap;
                end
            end
            r.fault_total = fault_count;
            expected_results = {expected_results, r};
        endfunction

        function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val != act_val) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_val, act_val);
            end
        endfunction

        function void check_result(t_res got);
            t_res exp_res;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            exp_res = expected_results.pop_front();
            compare_field("hit", exp_res.hit, got.hit);
            compare_field("frame_index", exp_res.frame_index, got.frame_index);
            compare_field("evicted_valid", exp_res.evicted_valid, got.evicted_valid);
            compare_field("evicted_page", exp_res.evicted_page, got.evicted_page);
            compare_field("fault_total", exp_res.fault_total, got.fault_total);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cpr_stream_if #(.T(t_req)) page_ch ();
    cpr_stream_if #(.T(t_cfg)) cfg_ch ();
    cpr_stream_if #(.T(t_res)) res_ch ();

    replacement_scoreboard sb = new();

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned rx_hold_left;
    int unsigned cycle_count;
    int unsigned ws_base;
    int unsigned ws_span;
    logic [5:0]  cap_plan [10] = '{6'd1, 6'd32, 6'd2, 6'd33, 6'd8,
                                   6'd0, 6'd63, 6'd17, 6'd5, 6'd32};

    clock_page_replacement u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_page_ch (page_ch),
        .i_cfg_ch  (cfg_ch),
        .o_res_ch  (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                sb.check_result(res_ch.data);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.set_capacity(cfg_ch.data.frame_capacity);
            end
            if (page_ch.valid && page_ch.ready) begin
                sb.note_reference(page_ch.data);
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            res_ch.ready <= 1'b0;
            rx_hold_left--;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_page(input logic [7:0] page);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            page_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        page_ch.valid <= 1'b1;
        page_ch.data.page_number <= page;
        @(posedge i_clk);
        while (!page_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        page_ch.valid <= 1'b0;
        while (sb.expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [5:0] cap);
        drain_results();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data.frame_capacity <= cap;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_page();
        if ($urandom_range(0, 99) < 15) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'(ws_base + $urandom_range(0, ws_span - 1));
    endfunction

    initial begin
        int unsigned eff;
        logic [7:0]  page_a;
        logic [7:0]  page_b;

        i_rst_n = 1'b0;
        page_ch.valid = 1'b0;
        page_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        tx_idle_pct = 21;
        rx_idle_pct = 64;
        rx_hold_left = 0;
        cycle_count = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill four frames, then evict around the ring until the hand sits at frame 2.
        write_capacity(6'd4);
        send_page(8'd0);
        send_page(8'd255);
        send_page(8'd0);
        send_page(8'd128);
        send_page(8'd1);
        send_page(8'd2);
        send_page(8'd255);
        send_page(8'd77);
        send_page(8'd3);
        send_page(8'd9);

        // Lowering the capacity leaves the hand outside it and hides frame 3.
        write_capacity(6'd2);
        send_page(8'd2);
        send_page(8'd40);
        send_page(8'd3);

        // Raising it again resumes filling; page 3 hits in frame 1 before the hidden copy in frame 3.
        write_capacity(6'd6);
        send_page(8'd3);
        send_page(8'd200);
        send_page(8'd201);

        write_capacity(6'd0);
        send_page(8'd7);
        send_page(8'd7);
        send_page(8'd8);

        write_capacity(6'd63);
        send_page(8'd250);
        send_page(8'd251);

        for (int p = 0; p < 10; p++) begin
            if (p == 4) begin
                tx_idle_pct = 64;
                rx_idle_pct = 21;
            end else if (p == 7) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_capacity(cap_plan[p]);
            eff = (cap_plan[p] == 0) ? 1 : ((cap_plan[p] > 32) ? 32 : cap_plan[p]);
            ws_base = $urandom_range(0, 255);
            ws_span = eff + eff / 2 + 1;
            if (p == 8) begin
                rx_hold_left = 400;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_page(pick_page());
            end
        end

        // Two different pages alternate with a single frame, so every reference after the first misses.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_capacity(6'd1);
        page_a = 8'($urandom_range(0, 255));
        page_b = ~page_a;
        for (int k = 0; k < MISS_REFS; k++) begin
            send_page(k[0] ? page_a : page_b);
        end

        drain_results();
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
